// ===== hdl/submessage_sort_dedup_top_assert.svh =====
// assertion macros used by the checker
`ifndef SUBMESSAGE_SORT_DEDUP_TOP_ASSERT_SVH
`define SUBMESSAGE_SORT_DEDUP_TOP_ASSERT_SVH

// same-cycle implication
`define SSD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("check failed");

// next-cycle implication
`define SSD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("check failed");

`endif

// ===== hdl/ssd_pkg.sv =====
package ssd_pkg;

   typedef struct packed {
      logic [63:0]        src_id_high;
      logic [63:0]        src_id_low;
      logic [63:0]        dst_id_high;
      logic [63:0]        dst_id_low;
      logic [7:0]         kind;
      logic signed [31:0] seq_count;
      logic               batch_end;
   } req_data_type;

   typedef struct packed {
      logic [4:0] arrival_index;
      logic       ignore;
      logic       final_res;
      logic [5:0] ignored_total;
      logic       overflowed;
   } rsp_data_type;

   typedef struct packed {
      logic [63:0]        src_hi;
      logic [63:0]        src_lo;
      logic [63:0]        dst_hi;
      logic [63:0]        dst_lo;
      logic [7:0]         kind;
      logic signed [31:0] count;
      logic [4:0]         idx;
   } entry_type;

   typedef struct packed {
      logic       ins;
      logic       pop;
      logic [7:0] hb_kind;
      logic [7:0] ak_kind;
   } cell_ctrl_type;

   localparam logic REG_HEARTBEAT = 1'b0;
   localparam logic REG_ACKNACK   = 1'b1;

   localparam logic [7:0] HEARTBEAT_RESET = 8'd7;
   localparam logic [7:0] ACKNACK_RESET   = 8'd6;

endpackage

// ===== hdl/submessage_sort_dedup_top.sv =====
// channel | ports                         | moves
// req     | req_valid req_stall req_data  | one descriptor per transfer
// rsp     | rsp_valid rsp_stall rsp_data  | one sorted entry per transfer
// csr     | APB write/read, 2 registers   | heartbeat and acknack codes
// Loading: one descriptor per cycle while req_stall is low, placed in the insertion cell chain.
// After batch_end the chain drains from cell 0, one result per cycle while the
// rsp output register is free or not stalled; req_stall is high while it drains.
// Synchronous reset empties the chain; stalls on rsp hold the output register.
module submessage_sort_dedup_top import ssd_pkg::*; #(
   parameter int MAX_ENTRIES = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_data_type rsp_data,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   localparam int FW = $clog2(MAX_ENTRIES + 1);

   logic [7:0]    hb_ff, ak_ff;
   logic [FW-1:0] fill_ff, fill_in;
   logic          ovf_ff, ovf_in;
   logic          drain_ff, drain_in;
   logic [FW-1:0] ign_ff, ign_in;
   logic          first_ff, first_in;
   entry_type     last_ff, last_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_data_type  rsp_data_ff, rsp_data_in;

   cell_ctrl_type ctrl;
   entry_type     new_e;
   entry_type     cell_e [MAX_ENTRIES];
   logic          cell_v [MAX_ENTRIES];
   logic          shift  [MAX_ENTRIES+1];
   logic          accept, pop, ign_now, counted_last;
   logic [FW-1:0] ign_next;

   assign pready    = 1'b1;
   assign prdata    = {24'd0, (paddr[2] == REG_ACKNACK) ? ak_ff : hb_ff};
   assign req_stall = drain_ff;
   assign accept    = req_valid && !drain_ff;
   assign pop       = drain_ff && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         hb_ff <= HEARTBEAT_RESET;
         ak_ff <= ACKNACK_RESET;
      end else if (psel && penable && pwrite) begin
         if (paddr[2] == REG_HEARTBEAT) hb_ff <= pwdata[7:0];
         else ak_ff <= pwdata[7:0];
      end
   end

   always_comb begin
      new_e.src_hi = req_data.src_id_high;
      new_e.src_lo = req_data.src_id_low;
      new_e.dst_hi = req_data.dst_id_high;
      new_e.dst_lo = req_data.dst_id_low;
      new_e.kind   = req_data.kind;
      new_e.count  = req_data.seq_count;
      new_e.idx    = 5'(fill_ff);
      ctrl.ins     = accept && (fill_ff != FW'(MAX_ENTRIES));
      ctrl.pop     = pop;
      ctrl.hb_kind = hb_ff;
      ctrl.ak_kind = ak_ff;
   end

   assign shift[0] = 1'b0;

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      entry_type le, re;
      logic      lv, rv;
      if (i == 0) begin : g_l0
         assign le = new_e;
         assign lv = 1'b1;
      end else begin : g_l
         assign le = cell_e[i-1];
         assign lv = cell_v[i-1];
      end
      if (i == MAX_ENTRIES - 1) begin : g_rl
         assign re = '0;
         assign rv = 1'b0;
      end else begin : g_r
         assign re = cell_e[i+1];
         assign rv = cell_v[i+1];
      end
      ssd_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_e       (new_e),
         .left_e      (le),
         .left_valid  (lv),
         .right_e     (re),
         .right_valid (rv),
         .shift_prev  (shift[i]),
         .shift_next  (shift[i+1]),
         .e           (cell_e[i]),
         .valid       (cell_v[i])
      );
   end

   always_comb begin
      fill_in      = fill_ff;
      ovf_in       = ovf_ff;
      drain_in     = drain_ff;
      ign_in       = ign_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      counted_last = (last_ff.kind == hb_ff) || (last_ff.kind == ak_ff);
      ign_now      = !first_ff && counted_last &&
                     last_ff.src_hi == cell_e[0].src_hi &&
                     last_ff.src_lo == cell_e[0].src_lo &&
                     last_ff.dst_hi == cell_e[0].dst_hi &&
                     last_ff.dst_lo == cell_e[0].dst_lo &&
                     last_ff.kind == cell_e[0].kind;
      ign_next     = ign_ff + FW'(ign_now);
      if (accept) begin
         if (ctrl.ins) fill_in = fill_ff + FW'(1);
         else ovf_in = 1'b1;
         if (req_data.batch_end) begin
            drain_in = 1'b1;
            first_in = 1'b1;
            ign_in   = '0;
         end
      end
      if (pop) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.arrival_index = cell_e[0].idx;
         rsp_data_in.ignore        = ign_now;
         rsp_data_in.final_res     = (fill_ff == FW'(1));
         rsp_data_in.ignored_total = (fill_ff == FW'(1)) ? 6'(ign_next) : 6'd0;
         rsp_data_in.overflowed    = ovf_ff;
         ign_in   = ign_next;
         first_in = 1'b0;
         last_in  = cell_e[0];
         fill_in  = fill_ff - FW'(1);
         if (fill_ff == FW'(1)) begin
            drain_in = 1'b0;
            ovf_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      last_ff     <= last_in;
      ign_ff      <= ign_in;
      first_ff    <= first_in;
      if (reset) begin
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         drain_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         ovf_ff       <= ovf_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/ssd_cell.sv =====
module ssd_cell import ssd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  entry_type     new_e,
   input  entry_type     left_e,
   input  logic          left_valid,
   input  entry_type     right_e,
   input  logic          right_valid,
   input  logic          shift_prev,
   output logic          shift_next,
   output entry_type     e,
   output logic          valid
);

   entry_type e_ff, e_in;
   logic      valid_ff, valid_in;
   logic      precedes, go, counted;

   always_comb begin
      counted = (new_e.kind == ctrl.hb_kind) || (new_e.kind == ctrl.ak_kind);
      if (new_e.src_hi != e_ff.src_hi) precedes = new_e.src_hi < e_ff.src_hi;
      else if (new_e.src_lo != e_ff.src_lo) precedes = new_e.src_lo < e_ff.src_lo;
      else if (new_e.dst_hi != e_ff.dst_hi) precedes = new_e.dst_hi < e_ff.dst_hi;
      else if (new_e.dst_lo != e_ff.dst_lo) precedes = new_e.dst_lo < e_ff.dst_lo;
      else if (new_e.kind != e_ff.kind) precedes = new_e.kind < e_ff.kind;
      else precedes = counted && (new_e.count > e_ff.count);
      // first free cell or first entry the new one precedes
      go = left_valid && (!valid_ff || precedes);
      shift_next = shift_prev || go;
   end

   always_comb begin
      e_in     = e_ff;
      valid_in = valid_ff;
      if (ctrl.ins) begin
         valid_in = valid_ff || go;
         if (shift_prev && left_valid) e_in = left_e;
         else if (go) e_in = new_e;
      end else if (ctrl.pop) begin
         e_in     = right_e;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      e_ff <= e_in;
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   assign e     = e_ff;
   assign valid = valid_ff;

endmodule

// ===== hdl/ssd_checker.sv =====
`include "submessage_sort_dedup_top_assert.svh"
module ssd_checker import ssd_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_data_type rsp_data
);

   `SSD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
   `SSD_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_data))
   `SSD_ASSERT_NOW(a_total_final, rsp_valid && !rsp_data.final_res, rsp_data.ignored_total == 6'd0)
   `SSD_ASSERT_NOW(a_total_counts, rsp_valid && rsp_data.final_res && rsp_data.ignore, rsp_data.ignored_total != 6'd0)

endmodule

bind submessage_sort_dedup_top ssd_checker u_ssd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== dv/submessage_sort_dedup_top_test.sv =====
module submessage_sort_dedup_top_test;
   import ssd_pkg::*;

   localparam int DEPTH = 32;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 80;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_data_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_data_type rsp_data;
   logic         psel;
   logic         penable;
   logic         pwrite;
   logic [2:0]   paddr;
   logic [31:0]  pwdata;
   logic [31:0]  prdata;
   logic         pready;

   submessage_sort_dedup_top #(.MAX_ENTRIES(DEPTH)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // shadow of the sorted entry store
   entry_type   sorted_store [DEPTH];
   int          fill_count;
   bit          dropped_seen;
   logic [7:0]  hb_code;
   logic [7:0]  ak_code;

   req_data_type desc_q[$];
   rsp_data_type sorted_q[$];
   int           mismatch_count;
   bit           gaps_on;
   bit           long_hold_req;
   int           cycle_count;

   function automatic bit counted_kind(logic [7:0] k);
      return k == hb_code || k == ak_code;
   endfunction

   function automatic bit orders_first(req_data_type d, entry_type e);
      if (d.src_id_high != e.src_hi) return d.src_id_high < e.src_hi;
      if (d.src_id_low != e.src_lo) return d.src_id_low < e.src_lo;
      if (d.dst_id_high != e.dst_hi) return d.dst_id_high < e.dst_hi;
      if (d.dst_id_low != e.dst_lo) return d.dst_id_low < e.dst_lo;
      if (d.kind != e.kind) return d.kind < e.kind;
      if (counted_kind(d.kind)) return $signed(d.seq_count) > $signed(e.count);
      return 1'b0;
   endfunction

   function automatic bit same_key(entry_type a, entry_type b);
      return a.src_hi == b.src_hi && a.src_lo == b.src_lo && a.dst_hi == b.dst_hi &&
             a.dst_lo == b.dst_lo && a.kind == b.kind;
   endfunction

   // insert one descriptor; on batch end push the sorted entries
   task automatic sort_descriptor(req_data_type d);
      int pos;
      int ignored;
      rsp_data_type r;
      if (fill_count < DEPTH) begin
         pos = fill_count;
         for (int i = 0; i < fill_count; i++) begin
            if (orders_first(d, sorted_store[i])) begin
               pos = i;
               break;
            end
         end
         for (int i = fill_count; i > pos; i--) sorted_store[i] = sorted_store[i - 1];
         sorted_store[pos] = '{d.src_id_high, d.src_id_low, d.dst_id_high, d.dst_id_low,
                               d.kind, d.seq_count, fill_count[4:0]};
         fill_count++;
      end else begin
         dropped_seen = 1'b1;
      end
      if (d.batch_end) begin
         ignored = 0;
         for (int i = 0; i < fill_count; i++) begin
            r = '0;
            r.arrival_index = sorted_store[i].idx;
            r.ignore = i > 0 && counted_kind(sorted_store[i - 1].kind) &&
                       same_key(sorted_store[i - 1], sorted_store[i]);
            if (r.ignore) ignored++;
            r.final_res = (i + 1 == fill_count);
            r.overflowed = dropped_seen;
            if (r.final_res) r.ignored_total = ignored[5:0];
            sorted_q.push_back(r);
         end
         fill_count = 0;
         dropped_seen = 1'b0;
      end
   endtask

   // sender
   int           tx_gap;
   bit           tx_next_valid;
   req_data_type tx_next_data;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         tx_gap = 0;
      end else begin
         tx_next_valid = req_valid;
         tx_next_data = req_data;
         if (req_valid && !req_stall) begin
            sort_descriptor(req_data);
            tx_next_valid = 1'b0;
         end
         if (!tx_next_valid) begin
            if (tx_gap > 0) begin
               tx_gap--;
            end else if (desc_q.size() > 0) begin
               tx_next_data = desc_q.pop_front();
               tx_next_valid = 1'b1;
               tx_gap = gaps_on ? $urandom_range(0, 8) : 0;
            end
         end
         req_valid <= tx_next_valid;
         req_data <= tx_next_data;
      end
   end

   // receiver and checker
   int           rx_wait;
   int           hold_left;
   bit           hold_taken;
   rsp_data_type want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rx_wait = 0;
         hold_left = 0;
         hold_taken = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (sorted_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result transfer: %p", rsp_data);
            end else begin
               want = sorted_q.pop_front();
               if (rsp_data.arrival_index !== want.arrival_index ||
                   rsp_data.ignore !== want.ignore ||
                   rsp_data.final_res !== want.final_res ||
                   rsp_data.ignored_total !== want.ignored_total ||
                   rsp_data.overflowed !== want.overflowed) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("result mismatch: expected %p actual %p", want, rsp_data);
               end
            end
            rx_wait = gaps_on ? $urandom_range(0, 8) : 0;
         end
         if (long_hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rx_wait > 0) begin
            rx_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("submessage_sort_dedup_top: mismatch");
         $finish;
      end
   end

   // small key pools so that duplicates occur often
   logic [63:0] id_pool [4];

   function automatic logic [63:0] pick_id();
      if ($urandom_range(0, 9) < 7) return id_pool[$urandom_range(0, 3)];
      return {$urandom, $urandom};
   endfunction

   function automatic req_data_type random_desc(bit last);
      req_data_type d;
      d.src_id_high = pick_id();
      d.src_id_low = pick_id();
      d.dst_id_high = pick_id();
      d.dst_id_low = pick_id();
      case ($urandom_range(0, 5))
         0, 1: d.kind = hb_code;
         2, 3: d.kind = ak_code;
         4: d.kind = $urandom_range(0, 1) ? 8'h00 : 8'hff;
         default: d.kind = 8'($urandom);
      endcase
      case ($urandom_range(0, 5))
         0: d.seq_count = 32'sh8000_0000;
         1: d.seq_count = 32'sh7fff_ffff;
         2: d.seq_count = $urandom_range(0, 3);
         3: d.seq_count = -1;
         default: d.seq_count = $urandom;
      endcase
      d.batch_end = last;
      return d;
   endfunction

   task automatic queue_batch(int len);
      for (int i = 0; i < len; i++) desc_q.push_back(random_desc(i == len - 1));
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (desc_q.size() > 0 || req_valid || sorted_q.size() > 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic reg_sel, logic [7:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= (reg_sel == REG_ACKNACK) ? 3'd4 : 3'd0;
      pwdata <= {24'h0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (reg_sel == REG_ACKNACK) ak_code = value;
      else hb_code = value;
   endtask

   req_data_type d;
   int           sent;
   int           len;
   int           phase;
   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      fill_count = 0;
      dropped_seen = 1'b0;
      hb_code = HEARTBEAT_RESET;
      ak_code = ACKNACK_RESET;
      mismatch_count = 0;
      gaps_on = 1'b0;
      long_hold_req = 1'b0;
      cycle_count = 0;
      id_pool[0] = '0;
      id_pool[1] = '1;
      id_pool[2] = {$urandom, $urandom};
      id_pool[3] = id_pool[2] + 1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, duplicates, count order, ties
      d = '0;
      d.batch_end = 1'b1;
      desc_q.push_back(d);
      d = '1;
      desc_q.push_back(d);
      d = '0;
      d.kind = HEARTBEAT_RESET;
      d.seq_count = 5;
      desc_q.push_back(d);
      d.seq_count = 32'sh7fff_ffff;
      desc_q.push_back(d);
      d.seq_count = 32'sh8000_0000;
      desc_q.push_back(d);
      d.seq_count = 5;
      desc_q.push_back(d);
      d.kind = ACKNACK_RESET;
      desc_q.push_back(d);
      desc_q.push_back(d);
      d.kind = 8'd3;
      d.seq_count = 1;
      desc_q.push_back(d);
      d.seq_count = 9;
      desc_q.push_back(d);
      d.src_id_high = '1;
      d.dst_id_low = '1;
      desc_q.push_back(d);
      d.src_id_high = '0;
      d.src_id_low = '1;
      d.kind = 8'hff;
      d.batch_end = 1'b1;
      desc_q.push_back(d);
      wait_idle();

      // config settings in turn, random batches after each
      sent = 0;
      phase = 0;
      while (sent < 470) begin
         case (phase % 5)
            0: begin csr_write(REG_HEARTBEAT, 8'h00); csr_write(REG_ACKNACK, 8'hff); end
            1: begin csr_write(REG_HEARTBEAT, 8'hff); csr_write(REG_ACKNACK, 8'h00); end
            2: begin csr_write(REG_HEARTBEAT, 8'h09); csr_write(REG_ACKNACK, 8'h09); end
            3: begin
               csr_write(REG_HEARTBEAT, 8'($urandom));
               csr_write(REG_ACKNACK, 8'($urandom));
            end
            default: begin
               csr_write(REG_HEARTBEAT, HEARTBEAT_RESET);
               csr_write(REG_ACKNACK, ACKNACK_RESET);
            end
         endcase
         gaps_on = phase % 3 != 2;
         if (phase == 2) begin
            // receiver holds off while full batches keep arriving
            gaps_on = 1'b0;
            long_hold_req = 1'b1;
            queue_batch(32);
            queue_batch(35);
            sent += 67;
         end
         for (int b = 0; b < 4; b++) begin
            case ($urandom_range(0, 9))
               0: len = 32;
               1: len = $urandom_range(33, 40);
               default: len = $urandom_range(1, 10);
            endcase
            queue_batch(len);
            sent += len;
         end
         wait_idle();
         phase++;
      end

      if (mismatch_count == 0)
         $display("submessage_sort_dedup_top: match");
      else
         $display("submessage_sort_dedup_top: mismatch");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ssd_pkg.sv
hdl/ssd_cell.sv
hdl/submessage_sort_dedup_top.sv
hdl/ssd_checker.sv
dv/submessage_sort_dedup_top_test.sv
